FILE: sv/sbsl_pkg.sv
// Package for the servo bank slew limiter: sizes, codes, the per-channel entry type
// and the start-up tables of the channel stores.
// Used by the top level, sbsl_step and the testbench; it depends on nothing.
package sbsl_pkg;

    localparam int CHANNELS       = 16;
    localparam int POSITION_BITS  = 12;
    localparam int STEP_BITS      = 8;
    localparam int CHAN_BITS      = 4;
    localparam int ADDR_BITS      = $clog2(CHANNELS);
    localparam int HOLD_BITS      = 10;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [HOLD_BITS-1:0]     RESET_POWER_HOLD     = 10'd200;
    localparam logic [POSITION_BITS-1:0] RESET_DEFAULT_TARGET = 12'd300;
    localparam logic [STEP_BITS-1:0]     RESET_DEFAULT_STEP   = 8'd1;

    localparam logic [1:0] CMD_SET_TARGET = 2'd0;
    localparam logic [1:0] CMD_TICK       = 2'd1;
    localparam logic [1:0] CMD_SET_LIMITS = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_POWER_HOLD     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_TARGET = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_STEP   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic [POSITION_BITS-1:0] high_limit;
        logic [POSITION_BITS-1:0] low_limit;
        logic [STEP_BITS-1:0]     step;
        logic [POSITION_BITS-1:0] target;
        logic [POSITION_BITS-1:0] position;
    } chan_entry_t;

    localparam int ENTRY_BITS = $bits(chan_entry_t);

    localparam logic [15:0] START_POS [16] = '{
        16'd300, 16'd300, 16'd300, 16'd300, 16'd100, 16'd100, 16'd270, 16'd300,
        16'd353, 16'd248, 16'd300, 16'd300, 16'd300, 16'd300, 16'd300, 16'd300
    };
    localparam logic [15:0] START_LOW [16] = '{
        16'd200, 16'd200, 16'd100, 16'd100, 16'd150, 16'd140, 16'd120, 16'd100,
        16'd280, 16'd230, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 16'd100
    };
    localparam logic [15:0] START_HIGH [16] = '{
        16'd400, 16'd400, 16'd500, 16'd500, 16'd500, 16'd400, 16'd500, 16'd500,
        16'd405, 16'd320, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500
    };
    localparam logic [STEP_BITS-1:0] START_STEP [16] = '{
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd4, 8'd4, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1
    };

    // Start-up contents of one channel entry; the tables repeat every sixteen channels.
    function automatic chan_entry_t reset_entry(input logic [ADDR_BITS-1:0] ch);
        chan_entry_t e;
        logic [3:0]  idx;
        idx          = 4'(ch);
        e.position   = START_POS[idx][POSITION_BITS-1:0];
        e.target     = START_POS[idx][POSITION_BITS-1:0];
        e.step       = START_STEP[idx];
        e.low_limit  = START_LOW[idx][POSITION_BITS-1:0];
        e.high_limit = START_HIGH[idx][POSITION_BITS-1:0];
        return e;
    endfunction

endpackage

FILE: sv/servo_bank_slew_limiter.sv
// Top level of the servo bank slew limiter: command sequencer, channel store,
// power-hold countdown and result register. Depends on sbsl_pkg, sbsl_ram, sbsl_step.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  tuser: cmd; tdata: channel..limit_high
//  m_        out        m_tvalid/m_tready  tuser: drive_on; tdata: channel, position; tlast
//  cfg_      in         cfg_valid/ready    cfg_index, cfg_data
//
// A set-target or set-limits request reads the channel entry from the store and then
// writes the merged entry back. A tick walks the channels one a cycle through the
// single read port of the store while the result side takes each report, and waits
// while the result side stalls. Reset is synchronous; entries never written since
// reset read as their start-up values.
module servo_bank_slew_limiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from 0: channel[3:0], target_position[15:4], step_size[23:16],
    // limit_low[35:24], limit_high[47:36].
    input  logic [47:0] s_tdata,
    // Bits from 0: cmd[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from 0: out_channel[3:0], out_position[15:4].
    output logic [15:0] m_tdata,
    // Bits from 0: drive_on[0].
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sbsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sbsl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int PB = sbsl_pkg::POSITION_BITS;
    localparam int AB = sbsl_pkg::ADDR_BITS;

    logic [sbsl_pkg::CHAN_BITS-1:0] in_channel;
    logic [PB-1:0]                  in_target;
    logic [sbsl_pkg::STEP_BITS-1:0] in_step;
    logic [PB-1:0]                  in_low;
    logic [PB-1:0]                  in_high;
    logic                           in_range;

    sbsl_pkg::state_t state_reg, state_next;
    logic [AB-1:0]                      pend_ch_reg, pend_ch_next;
    logic [sbsl_pkg::CHANNELS-1:0]      valid_reg, valid_next;
    logic [sbsl_pkg::HOLD_BITS-1:0]     countdown_reg, countdown_next;
    logic [sbsl_pkg::HOLD_BITS-1:0]     power_hold_reg;
    logic [PB-1:0]                      default_target_reg;
    logic [sbsl_pkg::STEP_BITS-1:0]     default_step_reg;
    logic                               m_tvalid_reg, m_tvalid_next;

    logic [1:0]                     cmd_reg;
    logic [PB-1:0]                  target_reg;
    logic [sbsl_pkg::STEP_BITS-1:0] step_reg;
    logic [PB-1:0]                  low_reg;
    logic [PB-1:0]                  high_reg;
    logic [sbsl_pkg::CHAN_BITS-1:0] out_channel_reg;
    logic [PB-1:0]                  out_position_reg;
    logic                           out_drive_reg;
    logic                           out_last_reg;

    logic                                req_load;
    logic                                out_load;
    logic                                ram_wr_en;
    logic                                ram_rd_en;
    logic [AB-1:0]                       ram_rd_addr;
    logic [sbsl_pkg::ENTRY_BITS-1:0]     ram_rd_data;
    sbsl_pkg::chan_entry_t               cur_entry;
    sbsl_pkg::chan_entry_t               wr_entry;
    logic [PB-1:0]                       new_position;

    assign in_channel = s_tdata[3:0];
    assign in_target  = s_tdata[15:4];
    assign in_step    = s_tdata[23:16];
    assign in_low     = s_tdata[35:24];
    assign in_high    = s_tdata[47:36];
    assign in_range   = 32'(in_channel) < sbsl_pkg::CHANNELS;

    assign cfg_ready = 1'b1;

    sbsl_ram #(
        .WIDTH (sbsl_pkg::ENTRY_BITS),
        .DEPTH (sbsl_pkg::CHANNELS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pend_ch_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cur_entry = valid_reg[pend_ch_reg] ? sbsl_pkg::chan_entry_t'(ram_rd_data)
                                              : sbsl_pkg::reset_entry(pend_ch_reg);

    sbsl_step u_step (
        .entry        (cur_entry),
        .new_position (new_position)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= sbsl_pkg::ST_IDLE;
            pend_ch_reg        <= '0;
            valid_reg          <= '0;
            countdown_reg      <= sbsl_pkg::RESET_POWER_HOLD;
            m_tvalid_reg       <= 1'b0;
            power_hold_reg     <= sbsl_pkg::RESET_POWER_HOLD;
            default_target_reg <= sbsl_pkg::RESET_DEFAULT_TARGET;
            default_step_reg   <= sbsl_pkg::RESET_DEFAULT_STEP;
        end else begin
            state_reg     <= state_next;
            pend_ch_reg   <= pend_ch_next;
            valid_reg     <= valid_next;
            countdown_reg <= countdown_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    sbsl_pkg::CFG_POWER_HOLD:     power_hold_reg <= cfg_data[9:0];
                    sbsl_pkg::CFG_DEFAULT_TARGET: default_target_reg <= cfg_data[PB-1:0];
                    sbsl_pkg::CFG_DEFAULT_STEP:   default_step_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_load) begin
            cmd_reg    <= s_tuser;
            target_reg <= (in_target != '0) ? in_target : default_target_reg;
            step_reg   <= (in_step != '0) ? in_step : default_step_reg;
            low_reg    <= in_low;
            high_reg   <= in_high;
        end
        if (out_load) begin
            out_channel_reg  <= sbsl_pkg::CHAN_BITS'(pend_ch_reg);
            out_position_reg <= new_position;
            out_drive_reg    <= (countdown_reg != '0);
            out_last_reg     <= (pend_ch_reg == AB'(sbsl_pkg::CHANNELS - 1));
        end
    end

    always_comb begin
        state_next     = state_reg;
        pend_ch_next   = pend_ch_reg;
        valid_next     = valid_reg;
        countdown_next = countdown_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        s_tready       = 1'b0;
        req_load       = 1'b0;
        out_load       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = pend_ch_reg;
        wr_entry       = cur_entry;

        unique case (state_reg)
            sbsl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_load = 1'b1;
                    unique case (s_tuser) inside
                        sbsl_pkg::CMD_SET_TARGET, sbsl_pkg::CMD_SET_LIMITS: begin
                            if (in_range) begin
                                pend_ch_next = AB'(in_channel);
                                ram_rd_en    = 1'b1;
                                ram_rd_addr  = AB'(in_channel);
                                state_next   = sbsl_pkg::ST_UPDATE;
                                if (s_tuser == sbsl_pkg::CMD_SET_TARGET) begin
                                    countdown_next = power_hold_reg;
                                end
                            end
                        end
                        sbsl_pkg::CMD_TICK: begin
                            if (countdown_reg != '0) begin
                                countdown_next = countdown_reg - 1'b1;
                            end
                            pend_ch_next = '0;
                            ram_rd_en    = 1'b1;
                            ram_rd_addr  = '0;
                            state_next   = sbsl_pkg::ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            sbsl_pkg::ST_UPDATE: begin
                ram_wr_en = 1'b1;
                valid_next[pend_ch_reg] = 1'b1;
                if (cmd_reg == sbsl_pkg::CMD_SET_TARGET) begin
                    wr_entry.target = target_reg;
                    wr_entry.step   = step_reg;
                end else begin
                    wr_entry.low_limit  = low_reg;
                    wr_entry.high_limit = high_reg;
                end
                state_next = sbsl_pkg::ST_IDLE;
            end
            sbsl_pkg::ST_TICK: begin
                if (!m_tvalid_reg || m_tready) begin
                    ram_wr_en               = 1'b1;
                    valid_next[pend_ch_reg] = 1'b1;
                    wr_entry.position       = new_position;
                    out_load                = 1'b1;
                    m_tvalid_next           = 1'b1;
                    if (pend_ch_reg == AB'(sbsl_pkg::CHANNELS - 1)) begin
                        state_next = sbsl_pkg::ST_IDLE;
                    end else begin
                        pend_ch_next = pend_ch_reg + 1'b1;
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = pend_ch_reg + 1'b1;
                    end
                end
            end
            default: state_next = sbsl_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_position_reg, out_channel_reg};
    assign m_tuser  = out_drive_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/sbsl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used for the channel store of the servo bank slew limiter.
module sbsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sbsl_step.sv
// Slew step of one channel: moves the position by its step toward the target,
// stopping at the target, while the limit test passes. Depends on sbsl_pkg.
module sbsl_step (
    input  sbsl_pkg::chan_entry_t                entry,
    output logic [sbsl_pkg::POSITION_BITS-1:0]   new_position
);

    logic [sbsl_pkg::POSITION_BITS-1:0] p;
    logic [sbsl_pkg::POSITION_BITS-1:0] t;
    logic [sbsl_pkg::POSITION_BITS-1:0] s;
    logic [sbsl_pkg::POSITION_BITS-1:0] gap;
    logic                               moving;

    always_comb begin
        p      = entry.position;
        t      = entry.target;
        s      = sbsl_pkg::POSITION_BITS'(entry.step);
        moving = (p != t)
                 && ((entry.high_limit >= p) || (entry.high_limit >= t))
                 && ((entry.low_limit <= p) || (entry.low_limit <= t));
        gap    = (p < t) ? (t - p) : (p - t);
        new_position = p;
        if (moving) begin
            if (gap > s) begin
                new_position = (p < t) ? (p + s) : (p - s);
            end else begin
                new_position = t;
            end
        end
    end

endmodule

FILE: dv/servo_bank_slew_limiter_tb.sv
// Self-checking testbench for servo_bank_slew_limiter: directed and random requests,
// with a scoreboard class that predicts every channel report of each tick.
// Depends on sbsl_pkg and the servo_bank_slew_limiter RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [sbsl_pkg::CHAN_BITS-1:0]     channel;
    logic [sbsl_pkg::POSITION_BITS-1:0] position;
    logic                               drive_on;
    logic                               last;
} servo_report_t;

class slew_scoreboard;
    logic [sbsl_pkg::POSITION_BITS-1:0] position [sbsl_pkg::CHANNELS];
    logic [sbsl_pkg::POSITION_BITS-1:0] target [sbsl_pkg::CHANNELS];
    logic [sbsl_pkg::STEP_BITS-1:0]     step [sbsl_pkg::CHANNELS];
    logic [sbsl_pkg::POSITION_BITS-1:0] low_lim [sbsl_pkg::CHANNELS];
    logic [sbsl_pkg::POSITION_BITS-1:0] high_lim [sbsl_pkg::CHANNELS];
    logic [sbsl_pkg::HOLD_BITS-1:0]     countdown;
    logic [sbsl_pkg::HOLD_BITS-1:0]     hold_ticks;
    logic [sbsl_pkg::POSITION_BITS-1:0] dflt_target;
    logic [sbsl_pkg::STEP_BITS-1:0]     dflt_step;
    servo_report_t                      pending_reports [$];
    int                                 errors;

    function new();
        int start_pos [16] = '{300, 300, 300, 300, 100, 100, 270, 300,
                               353, 248, 300, 300, 300, 300, 300, 300};
        int start_low [16] = '{200, 200, 100, 100, 150, 140, 120, 100,
                               280, 230, 100, 100, 100, 100, 100, 100};
        int start_high [16] = '{400, 400, 500, 500, 500, 400, 500, 500,
                                405, 320, 500, 500, 500, 500, 500, 500};
        for (int i = 0; i < sbsl_pkg::CHANNELS; i++) begin
            position[i] = sbsl_pkg::POSITION_BITS'(start_pos[i % 16]);
            target[i]   = sbsl_pkg::POSITION_BITS'(start_pos[i % 16]);
            step[i]     = ((i % 16) == 8 || (i % 16) == 9) ? 8'd4 : 8'd1;
            low_lim[i]  = sbsl_pkg::POSITION_BITS'(start_low[i % 16]);
            high_lim[i] = sbsl_pkg::POSITION_BITS'(start_high[i % 16]);
        end
        countdown   = sbsl_pkg::RESET_POWER_HOLD;
        hold_ticks  = sbsl_pkg::RESET_POWER_HOLD;
        dflt_target = sbsl_pkg::RESET_DEFAULT_TARGET;
        dflt_step   = sbsl_pkg::RESET_DEFAULT_STEP;
        errors      = 0;
    endfunction

    function void write_register(logic [sbsl_pkg::CFG_INDEX_BITS-1:0] index,
                                 logic [sbsl_pkg::CFG_DATA_BITS-1:0] data);
        case (index)
            sbsl_pkg::CFG_POWER_HOLD:     hold_ticks  = data[sbsl_pkg::HOLD_BITS-1:0];
            sbsl_pkg::CFG_DEFAULT_TARGET: dflt_target = data[sbsl_pkg::POSITION_BITS-1:0];
            sbsl_pkg::CFG_DEFAULT_STEP:   dflt_step   = data[sbsl_pkg::STEP_BITS-1:0];
            default: ;
        endcase
    endfunction

    function void apply_request(logic [1:0] cmd, logic [47:0] payload);
        int            ch;
        int            p;
        int            t;
        int            s;
        int            l;
        int            h;
        servo_report_t rep;
        ch = int'(payload[3:0]);
        case (cmd)
            sbsl_pkg::CMD_SET_TARGET: begin
                if (ch < sbsl_pkg::CHANNELS) begin
                    target[ch] = (payload[15:4] != 0) ? payload[15:4] : dflt_target;
                    step[ch]   = (payload[23:16] != 0) ? payload[23:16] : dflt_step;
                    countdown  = hold_ticks;
                end
            end
            sbsl_pkg::CMD_SET_LIMITS: begin
                if (ch < sbsl_pkg::CHANNELS) begin
                    low_lim[ch]  = payload[35:24];
                    high_lim[ch] = payload[47:36];
                end
            end
            sbsl_pkg::CMD_TICK: begin
                if (countdown > 0) begin
                    countdown = countdown - 1'b1;
                end
                for (int i = 0; i < sbsl_pkg::CHANNELS; i++) begin
                    p = int'(position[i]);
                    t = int'(target[i]);
                    s = int'(step[i]);
                    l = int'(low_lim[i]);
                    h = int'(high_lim[i]);
                    if (p != t && (h >= p || h >= t) && (l <= p || l <= t)) begin
                        if (p < t) begin
                            p = (t - p > s) ? p + s : t;
                        end else begin
                            p = (p - t > s) ? p - s : t;
                        end
                        position[i] = sbsl_pkg::POSITION_BITS'(p);
                    end
                    rep.channel  = sbsl_pkg::CHAN_BITS'(i);
                    rep.position = position[i];
                    rep.drive_on = (countdown > 0);
                    rep.last     = (i == sbsl_pkg::CHANNELS - 1);
                    pending_reports.push_back(rep);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_report(logic [15:0] data, logic user, logic tlast);
        servo_report_t exp_rep;
        if (pending_reports.size() == 0) begin
            $error("unexpected report: channel %0d, position %0d", data[3:0], data[15:4]);
            errors++;
            return;
        end
        exp_rep = pending_reports.pop_front();
        if (data[3:0] !== exp_rep.channel) begin
            $error("out_channel: expected %0d, actual %0d", exp_rep.channel, data[3:0]);
            errors++;
        end
        if (data[15:4] !== exp_rep.position) begin
            $error("out_position: expected %0d, actual %0d", exp_rep.position, data[15:4]);
            errors++;
        end
        if (user !== exp_rep.drive_on) begin
            $error("drive_on: expected %0d, actual %0d", exp_rep.drive_on, user);
            errors++;
        end
        if (tlast !== exp_rep.last) begin
            $error("last: expected %0d, actual %0d", exp_rep.last, tlast);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_reports.size();
    endfunction
endclass

module servo_bank_slew_limiter_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sbsl_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sbsl_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    int send_idle_pct = 12;
    int recv_idle_pct = 82;
    int stall_cycles = 0;

    slew_scoreboard sb = new();

    servo_bank_slew_limiter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_report(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [47:0] pack_request(logic [3:0] ch, logic [11:0] tgt,
                                                 logic [7:0] stp, logic [11:0] lo,
                                                 logic [11:0] hi);
        return {hi, lo, stp, tgt, ch};
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [47:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        sb.apply_request(cmd, payload);
    endtask

    // Waits until every predicted report has arrived, then lets the block settle.
    task automatic settle(input int quiet_cycles);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (quiet_cycles) @(posedge aclk);
    endtask

    task automatic configure(input logic [11:0] hold, input logic [11:0] tgt,
                             input logic [11:0] stp);
        logic [11:0] vals [3];
        vals = '{hold, tgt, stp};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= sbsl_pkg::CFG_INDEX_BITS'(i);
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_register(sbsl_pkg::CFG_INDEX_BITS'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(input int count, input int pause_at);
        int          done_cnt;
        int          r;
        logic [47:0] payload;
        logic [11:0] lo;
        logic [11:0] hi;
        done_cnt = 0;
        while (done_cnt < count) begin
            if (done_cnt == pause_at) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.outstanding() != 0);
            end
            payload = 48'({$urandom(), $urandom()});
            r = $urandom_range(99);
            if (r < 35) begin
                if ($urandom_range(9) == 0) payload[15:4] = '0;
                if ($urandom_range(9) == 0) payload[23:16] = '0;
                send_request(sbsl_pkg::CMD_SET_TARGET, payload);
                done_cnt++;
            end else if (r < 70) begin
                send_request(sbsl_pkg::CMD_TICK, payload);
                done_cnt++;
            end else if (r < 92) begin
                if ($urandom_range(9) < 7) begin
                    lo = 12'($urandom_range(2047));
                    hi = 12'($urandom_range(4095, lo));
                    payload[35:24] = lo;
                    payload[47:36] = hi;
                end
                send_request(sbsl_pkg::CMD_SET_LIMITS, payload);
                done_cnt++;
            end else begin
                send_request(CMD_UNUSED, payload);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(sbsl_pkg::CMD_TICK, '0);
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd0, 12'd4095, 8'd255, 12'd0, 12'd0));
        send_request(sbsl_pkg::CMD_TICK, '1);
        send_request(sbsl_pkg::CMD_TICK, '0);
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd1, 12'd0, 8'd0, 12'hfff, 12'hfff));
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd2, 12'd305, 8'd200, 12'd0, 12'd0));
        send_request(sbsl_pkg::CMD_TICK, '0);
        send_request(sbsl_pkg::CMD_SET_LIMITS,
                     pack_request(4'd3, 12'd0, 8'd0, 12'd4095, 12'd0));
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd3, 12'd1, 8'd1, 12'd0, 12'd0));
        send_request(sbsl_pkg::CMD_TICK, '0);
        send_request(sbsl_pkg::CMD_SET_LIMITS,
                     pack_request(4'd15, 12'd0, 8'd0, 12'd0, 12'd4095));
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd15, 12'd4000, 8'd128, 12'd0, 12'd0));
        send_request(CMD_UNUSED, '1);
        send_request(sbsl_pkg::CMD_TICK, '0);

        settle(4);
        configure(12'd0, 12'd0, 12'd0);
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd6, 12'd0, 8'd0, 12'd0, 12'd0));
        send_request(sbsl_pkg::CMD_SET_LIMITS,
                     pack_request(4'd6, 12'd0, 8'd0, 12'd0, 12'd4095));
        send_request(sbsl_pkg::CMD_SET_TARGET,
                     pack_request(4'd7, 12'd4095, 8'd0, 12'd0, 12'd0));
        send_request(sbsl_pkg::CMD_TICK, '0);
        send_request(sbsl_pkg::CMD_TICK, '0);

        settle(4);
        configure(12'd1023, 12'd4095, 12'd255);
        random_requests(28, 14);

        settle(4);
        configure(12'd1, 12'($urandom_range(4095)), 12'($urandom_range(255)));
        send_idle_pct = 82;
        recv_idle_pct = 12;
        random_requests(28, -1);

        settle(4);
        configure(12'($urandom_range(1023)), 12'($urandom_range(4095)), 12'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(28, -1);

        settle(40);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sbsl_pkg.sv
sv/sbsl_ram.sv
sv/sbsl_step.sv
sv/servo_bank_slew_limiter.sv
dv/servo_bank_slew_limiter_tb.sv
